>>> design/dead_reckoning_pose_integrator_defines.svh
// Assertion helpers for the pose integrator. Each expects clk and rst_n in scope.
`ifndef DEAD_RECKONING_POSE_INTEGRATOR_DEFINES_SVH
`define DEAD_RECKONING_POSE_INTEGRATOR_DEFINES_SVH

// Same-cycle implication
`define DRPI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define DRPI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/drpi_pkg.sv
`timescale 1ns / 1ps
package drpi_pkg;

  // Field widths
  localparam int KIND_W = 2;
  localparam int YAW_W  = 17;
  localparam int DIST_W = 32;
  localparam int POS_W  = 40;
  localparam int BAM_W  = 16;

  // Internal widths
  localparam int D_W    = 18;  // yaw difference
  localparam int DS_W   = 33;  // distance step
  localparam int XY_W   = 51;  // CORDIC datapath
  localparam int Z_W    = 33;  // CORDIC angle residue
  localparam int FRAC_SH = 16;
  localparam int DXY_W  = XY_W - FRAC_SH;

  // Angle conversion constants
  localparam int unsigned DEG_TURN   = 36000;
  localparam int unsigned DEG_OFFSET = 144000;  // four turns
  // (r * 65536 + 18000) / 36000 scaled down by 16: (r * 4096 + 1125) / 2250
  localparam int unsigned BAM_HALF_SC  = 1125;
  localparam int          BAM_RECIP_W  = 29;
  localparam logic [28:0] BAM_RECIP    = 29'd488671835;  // ceil(2^40 / 2250)
  localparam int          BAM_RECIP_SH = 40;
  localparam int DIV_STEPS = 1;                 // one reciprocal multiply

  // CORDIC constants
  localparam logic signed [30:0] GAIN_Q30 = 31'sd652032874;
  localparam int ATAN_IDX_W = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK = 2'd0,
    KIND_ARM  = 2'd1,
    KIND_SET  = 2'd2
  } kind_t;

  typedef logic signed [YAW_W-1:0]  yaw_t;
  typedef logic signed [DIST_W-1:0] dist_t;
  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic [BAM_W-1:0]         bam_t;
  typedef logic signed [D_W-1:0]    dyaw_t;
  typedef logic signed [DS_W-1:0]   dstep_t;
  typedef logic signed [DXY_W-1:0]  dxy_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

  typedef struct packed {
    logic mul;
    logic load;
    logic step;
  } rot_ctl_t;

  // Arctangent of 2^-i in 2^32 units per turn
  function automatic logic [31:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

>>> design/drpi_ifs.sv
`timescale 1ns / 1ps
interface drpi_in_if;
  import drpi_pkg::*;
  logic  valid;
  logic  ready;
  logic [KIND_W-1:0] kind;
  yaw_t  yaw_sample;
  dist_t odo_distance;
  logic  enable;

  modport source (output valid, kind, yaw_sample, odo_distance, enable, input ready);
  modport sink   (input valid, kind, yaw_sample, odo_distance, enable, output ready);
endinterface

interface drpi_out_if;
  import drpi_pkg::*;
  logic valid;
  logic ready;
  pos_t pos_x;
  pos_t pos_y;
  bam_t heading;
  logic is_active;

  modport source (output valid, pos_x, pos_y, heading, is_active, input ready);
  modport sink   (input valid, pos_x, pos_y, heading, is_active, output ready);
endinterface

interface drpi_cfg_if;
  logic valid;
  logic ready;
  logic heading_negate;

  modport source (output valid, heading_negate, input ready);
  modport sink   (input valid, heading_negate, output ready);
endinterface

>>> design/drpi_bam_div.sv
`timescale 1ns / 1ps
// Yaw difference to binary angle: reduce into one turn, then form
// (r * 65536 + 18000) / 36000 as (r * 4096 + 1125) / 2250 with one
// reciprocal multiply (exact for every reduced angle).
module drpi_bam_div (
  input  logic               clk,
  input  drpi_pkg::div_ctl_t ctl,
  input  drpi_pkg::dyaw_t    d,
  output drpi_pkg::bam_t     heading
);
  import drpi_pkg::*;

  localparam int T_W  = 19;
  localparam int R_W  = 16;
  localparam int LO_W = 12;
  localparam int N_W  = R_W + LO_W;
  localparam int P_W  = N_W + BAM_RECIP_W;

  logic [R_W-1:0]   rem_r;
  logic [BAM_W-1:0] q_r;

  logic signed [T_W:0] t_s;
  logic [T_W-1:0]      t_red;
  logic [R_W-1:0]      r_mod;
  logic [N_W-1:0]      num;
  logic [P_W-1:0]      prod;

  // Offset positive and remove whole turns
  always_comb begin
    t_s   = (T_W+1)'(d) + (T_W+1)'(DEG_OFFSET);
    t_red = t_s[T_W-1:0];
    if (t_red >= T_W'(4 * DEG_TURN)) t_red = t_red - T_W'(4 * DEG_TURN);
    if (t_red >= T_W'(2 * DEG_TURN)) t_red = t_red - T_W'(2 * DEG_TURN);
    if (t_red >= T_W'(DEG_TURN))     t_red = t_red - T_W'(DEG_TURN);
    r_mod = t_red[R_W-1:0];
  end

  // Scale the reduced angle, add the rounding half, multiply by the reciprocal
  assign num  = {rem_r, LO_W'(BAM_HALF_SC)};
  assign prod = P_W'(num) * P_W'(BAM_RECIP);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem_r <= r_mod;
    end else if (ctl.step) begin
      q_r   <= prod[BAM_RECIP_SH+BAM_W-1:BAM_RECIP_SH];
    end
  end

  assign heading = q_r;

endmodule

>>> design/drpi_cordic.sv
`timescale 1ns / 1ps
// Gain-compensated rotation of (ds, 0) by the heading, one step per cycle.
module drpi_cordic #(
  parameter int IDX_W = 4
) (
  input  logic               clk,
  input  drpi_pkg::rot_ctl_t ctl,
  input  drpi_pkg::dstep_t   ds,
  input  drpi_pkg::bam_t     ang,
  input  logic [IDX_W-1:0]   idx,
  output drpi_pkg::dxy_t     dx,
  output drpi_pkg::dxy_t     dy
);
  import drpi_pkg::*;

  logic signed [XY_W-1:0] prod_r;
  logic signed [XY_W-1:0] x_r;
  logic signed [XY_W-1:0] y_r;
  logic signed [Z_W-1:0]  z_r;

  logic signed [63:0]     prod;
  logic                   flip;
  logic [31:0]            z32;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic signed [Z_W-1:0]  atn;
  logic signed [XY_W-1:0] xr;
  logic signed [XY_W-1:0] yr;

  // Scale by the CORDIC gain
  assign prod = ds * GAIN_Q30;

  // Half-turn pre-rotation for the second and third quadrants
  assign flip = ang[BAM_W-1] ^ ang[BAM_W-2];
  assign z32  = {ang[BAM_W-1] ^ flip, ang[BAM_W-2:0], 16'h0000};

  assign xs  = x_r >>> idx;
  assign ys  = y_r >>> idx;
  assign atn = signed'({1'b0, atan_lut(ATAN_IDX_W'(idx))});

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod_r <= XY_W'(prod >>> 14);
    end
    if (ctl.load) begin
      x_r <= flip ? -prod_r : prod_r;
      y_r <= '0;
      z_r <= Z_W'(signed'(z32));
    end else if (ctl.step) begin
      if (!z_r[Z_W-1]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atn;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atn;
      end
    end
  end

  // Round to nearest, halves up
  assign xr = x_r + XY_W'(32768);
  assign yr = y_r + XY_W'(32768);
  assign dx = xr[XY_W-1:FRAC_SH];
  assign dy = yr[XY_W-1:FRAC_SH];

endmodule

>>> design/dead_reckoning_pose_integrator.sv
`timescale 1ns / 1ps
`include "dead_reckoning_pose_integrator_defines.svh"
// Channel  Dir  Handshake      Payload
// in_ch    in   valid/ready    kind, yaw_sample, odo_distance, enable
// out_ch   out  valid/ready    pos_x, pos_y, heading, is_active
// cfg_ch   in   valid/ready    heading_negate (always ready)
//
// An accepted active tick passes through MOD (reduction and gain multiply), DIV
// (the reciprocal multiply that gives the angle), LOAD (preload), ROT (the CORDIC
// steps in the shared rotator), ACC (accumulate) and DONE (output). Other items
// go from idle straight to DONE.
// in_ch.ready is high only while idle. A result waiting on out_ch holds the next
// item in its last cycle.
// rst_n is synchronous, active low, and zeroes the pose, offset and gate.
module dead_reckoning_pose_integrator #(
  parameter int CORDIC_STEPS = 16
) (
  input logic       clk,
  input logic       rst_n,
  drpi_in_if.sink   in_ch,
  drpi_out_if.source out_ch,
  drpi_cfg_if.sink  cfg_ch
);
  import drpi_pkg::*;

  localparam int IDX_W = $clog2(CORDIC_STEPS);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MOD  = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_LOAD = 7'b0001000,
    S_ROT  = 7'b0010000,
    S_ACC  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;

  pos_t   x_acc_r;
  pos_t   y_acc_r;
  bam_t   heading_r;
  yaw_t   yaw_off_r;
  dist_t  prev_dist_r;
  logic   active_r;
  logic   neg_r;
  dyaw_t  d_r;
  dstep_t ds_r;

  logic   out_valid_r;
  pos_t   out_x_r;
  pos_t   out_y_r;
  bam_t   out_hdg_r;
  logic   out_act_r;

  logic     in_acc;
  logic     is_tick;
  logic     out_free;
  div_ctl_t div_ctl;
  rot_ctl_t rot_ctl;
  bam_t     bam_q;
  dxy_t     dx;
  dxy_t     dy;

  function automatic pos_t sat_pos(input logic signed [POS_W+1:0] v);
    logic signed [POS_W+1:0] hi;
    logic signed [POS_W+1:0] lo;
    hi = (POS_W+2)'({1'b0, {(POS_W-1){1'b1}}});
    lo = -hi - (POS_W+2)'(1);
    if (v > hi) return POS_W'(hi);
    if (v < lo) return POS_W'(lo);
    return POS_W'(v);
  endfunction

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign is_tick      = (in_ch.kind == KIND_TICK) && active_r;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Sequence the shared units
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = is_tick ? S_MOD : S_DONE;
      S_MOD: begin
        state_nxt = S_DIV;
        cnt_nxt   = '0;
      end
      S_DIV: begin
        if (cnt_r == IDX_W'(DIV_STEPS - 1)) begin
          state_nxt = S_LOAD;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      S_LOAD: state_nxt = S_ROT;
      S_ROT: begin
        if (cnt_r == IDX_W'(CORDIC_STEPS - 1)) begin
          state_nxt = S_ACC;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      S_ACC:  state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign div_ctl.load = (state_r == S_MOD);
  assign div_ctl.step = (state_r == S_DIV);
  assign rot_ctl.mul  = (state_r == S_MOD);
  assign rot_ctl.load = (state_r == S_LOAD);
  assign rot_ctl.step = (state_r == S_ROT);

  drpi_bam_div u_div (
    .clk     (clk),
    .ctl     (div_ctl),
    .d       (d_r),
    .heading (bam_q)
  );

  drpi_cordic #(.IDX_W(IDX_W)) u_rot (
    .clk (clk),
    .ctl (rot_ctl),
    .ds  (ds_r),
    .ang (bam_q),
    .idx (cnt_r),
    .dx  (dx),
    .dy  (dy)
  );

  // Advance control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      neg_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_ch.valid) neg_r <= cfg_ch.heading_negate;
    end
  end

  // Update pose state on accepted items and after rotation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_acc_r     <= '0;
      y_acc_r     <= '0;
      heading_r   <= '0;
      yaw_off_r   <= '0;
      prev_dist_r <= '0;
      active_r    <= 1'b0;
    end else if (in_acc) begin
      priority if (in_ch.kind == KIND_ARM) begin
        yaw_off_r   <= in_ch.yaw_sample;
        x_acc_r     <= '0;
        y_acc_r     <= '0;
        heading_r   <= '0;
        prev_dist_r <= '0;
      end else if (in_ch.kind == KIND_SET) begin
        active_r <= in_ch.enable;
        if (in_ch.enable) prev_dist_r <= in_ch.odo_distance;
      end else if (is_tick) begin
        prev_dist_r <= in_ch.odo_distance;
      end else begin
        active_r <= active_r;
      end
    end else if (state_r == S_ACC) begin
      x_acc_r   <= sat_pos((POS_W+2)'(x_acc_r) + (POS_W+2)'(dx));
      y_acc_r   <= sat_pos((POS_W+2)'(y_acc_r) + (POS_W+2)'(dy));
      heading_r <= bam_q;
    end
  end

  // Latch tick operands
  always_ff @(posedge clk) begin
    if (in_acc && is_tick) begin
      d_r  <= neg_r ? (D_W'(yaw_off_r) - D_W'(in_ch.yaw_sample))
                    : (D_W'(in_ch.yaw_sample) - D_W'(yaw_off_r));
      ds_r <= DS_W'(in_ch.odo_distance) - DS_W'(prev_dist_r);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_x_r   <= x_acc_r;
      out_y_r   <= y_acc_r;
      out_hdg_r <= heading_r;
      out_act_r <= active_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pos_x     = out_x_r;
  assign out_ch.pos_y     = out_y_r;
  assign out_ch.heading   = out_hdg_r;
  assign out_ch.is_active = out_act_r;

  `DRPI_ASSERT_NXT(a_tick_starts, in_acc && is_tick, state_r == S_MOD, "active tick not started")
  `DRPI_ASSERT_NXT(a_other_done, in_acc && !is_tick, state_r == S_DONE, "non-tick item not done")
  `DRPI_ASSERT_IMP(a_out_from_done, $rose(out_valid_r), $past(state_r) == S_DONE, "stray result")
  `DRPI_ASSERT_IMP(a_prev_hold, $past(rst_n) && !$past(in_acc), $stable(prev_dist_r), "distance moved")
  `DRPI_ASSERT_IMP(a_rot_cnt, state_r == S_ROT && $past(state_r) == S_LOAD, cnt_r == '0, "step count")

endmodule

>>> tb/sv/tb_dead_reckoning_pose_integrator.sv
`timescale 1ns / 1ps
module tb_dead_reckoning_pose_integrator;
  import drpi_pkg::*;

  localparam int             ROT_STEPS    = 16;
  localparam longint         ROT_GAIN     = 64'sd652032874;
  localparam longint         POS_HI       = 64'sd549755813887;
  localparam longint         POS_LO       = -64'sd549755813888;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
  localparam int             ROUTE_LEN    = 24;
  localparam int             PHASE_ITEMS  = 275;
  localparam int             HAUL_TICKS   = 200;
  localparam int             SETTLE_LIMIT = 20000;
  localparam int             SETTLE_GAP   = 40;
  localparam longint         TIMEOUT_NS   = 64'd10_000_000;

  typedef struct {
    pos_t x;
    pos_t y;
    bam_t heading;
    logic active;
  } pose_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    yaw_t  yaw;
    dist_t distance;
    logic  en;
    bit    typed;
    pos_t  ex;
    pos_t  ey;
    bam_t  eh;
    logic  ea;
  } route_row_t;

  logic clk;
  logic rst_n;

  drpi_in_if  in_ch ();
  drpi_out_if out_ch ();
  drpi_cfg_if cfg_ch ();

  dead_reckoning_pose_integrator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Arctangent of 2^-i, 2^32 units per turn
  int unsigned arctan_q32 [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  // Estimated block state
  pos_t  est_x;
  pos_t  est_y;
  bam_t  est_heading;
  yaw_t  est_offset;
  dist_t est_prev;
  logic  est_active;
  logic  est_negate;

  pose_t      pending_poses [$];
  route_row_t route [ROUTE_LEN];
  int         failures;
  int         items_sent;
  int         feed_idle_pct;
  int         sink_stall_pct;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop
  initial begin
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

  function automatic void log_mismatch(input string msg);
    failures++;
    if (failures <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic pos_t clamp_pos(input longint v);
    if (v > POS_HI) return pos_t'(POS_HI);
    if (v < POS_LO) return pos_t'(POS_LO);
    return pos_t'(v);
  endfunction

  // Round the yaw difference to a binary angle, wrap into one turn
  function automatic bam_t yaw_to_bam(input longint d);
    longint num;
    num = (d + 144000) * 65536 + 18000;
    return bam_t'(num / 36000);
  endfunction

  // Project a distance step onto x and y by gain-corrected CORDIC rotation
  function automatic void cordic_project(input longint ds, input bam_t ang,
                                         output longint dx, output longint dy);
    longint      x;
    longint      y;
    longint      z;
    longint      xs;
    longint      ys;
    logic [31:0] z32;
    x = (ds * ROT_GAIN) >>> 14;
    y = 0;
    z32 = {ang, 16'h0000};
    // fold the back half-plane with a half-turn
    if (z32[31:30] == 2'b01 || z32[31:30] == 2'b10) begin
      x = -x;
      z32 = z32 - 32'h8000_0000;
    end
    z = longint'(signed'(z32));
    for (int i = 0; i < ROT_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(arctan_q32[i]);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(arctan_q32[i]);
      end
    end
    dx = (x + 32768) >>> 16;
    dy = (y + 32768) >>> 16;
  endfunction

  // Advance the estimated state by one item and report the pose
  function automatic void integrate_pose(input route_row_t r, output pose_t p);
    longint d;
    longint ds;
    longint dx;
    longint dy;
    case (r.kind)
      KIND_ARM: begin
        est_offset  = r.yaw;
        est_x       = '0;
        est_y       = '0;
        est_heading = '0;
        est_prev    = '0;
      end
      KIND_SET: begin
        est_active = r.en;
        if (r.en) est_prev = r.distance;
      end
      KIND_TICK: begin
        if (est_active) begin
          d = longint'(r.yaw) - longint'(est_offset);
          if (est_negate) d = -d;
          est_heading = yaw_to_bam(d);
          ds = longint'(r.distance) - longint'(est_prev);
          est_prev = r.distance;
          cordic_project(ds, est_heading, dx, dy);
          est_x = clamp_pos(longint'(est_x) + dx);
          est_y = clamp_pos(longint'(est_y) + dy);
        end
      end
      default: ;
    endcase
    p.x       = est_x;
    p.y       = est_y;
    p.heading = est_heading;
    p.active  = est_active;
  endfunction

  function automatic route_row_t make_row(input logic [KIND_W-1:0] kind, input yaw_t yaw,
                                          input dist_t distance, input logic en);
    route_row_t r;
    r = '{kind, yaw, distance, en, 1'b0, '0, '0, '0, 1'b0};
    return r;
  endfunction

  function automatic yaw_t rand_yaw();
    if ($urandom_range(0, 99) < 5) return yaw_t'($urandom);
    return yaw_t'(int'($urandom_range(0, 72000)) - 36000);
  endfunction

  // Directed rows: fixed poses only where they are obvious
  task automatic load_route();
    // closed gate, unused kind, arm and open
    route[0]  = '{KIND_TICK, 36000, 32'h7FFF_FFFF, 1'b1, 1'b1, 0, 0, 0, 1'b0};
    route[1]  = '{KIND_SET, -36000, 32'h1234_5678, 1'b0, 1'b1, 0, 0, 0, 1'b0};
    route[2]  = '{KIND_NONE, 36000, 32'hFFFF_FFFF, 1'b1, 1'b1, 0, 0, 0, 1'b0};
    route[3]  = '{KIND_ARM, -36000, 32'h7FFF_FFFF, 1'b1, 1'b1, 0, 0, 0, 1'b0};
    route[4]  = '{KIND_SET, 0, 32'h0000_0000, 1'b1, 1'b1, 0, 0, 0, 1'b1};
    // zero step at zero and quarter turn
    route[5]  = '{KIND_TICK, -36000, 32'h0000_0000, 1'b0, 1'b1, 0, 0, 0, 1'b1};
    route[6]  = '{KIND_TICK, -27000, 32'h0000_0000, 1'b1, 1'b1, 0, 0, 16384, 1'b1};
    // full-scale steps, half turn, two turns, wrap just below zero
    route[7]  = '{KIND_TICK, -36000, 32'h7FFF_FFFF, 1'b0, 1'b0, 0, 0, 0, 1'b0};
    route[8]  = '{KIND_TICK, -18000, 32'h8000_0000, 1'b1, 1'b0, 0, 0, 0, 1'b0};
    route[9]  = '{KIND_TICK, 36000, 32'h7FFF_FFFF, 1'b1, 1'b0, 0, 0, 0, 1'b0};
    route[10] = '{KIND_TICK, -35999, 32'h7FFF_FFFF, 1'b0, 1'b0, 0, 0, 0, 1'b0};
    route[11] = '{KIND_TICK, 35999, 32'h0000_0001, 1'b1, 1'b0, 0, 0, 0, 1'b0};
    // close the gate: distance is kept, ticks are ignored; then reopen and step again
    route[12] = '{KIND_SET, 0, 32'h0000_0005, 1'b0, 1'b0, 0, 0, 0, 1'b0};
    route[13] = '{KIND_TICK, 1234, 32'h7FFF_FFFF, 1'b1, 1'b0, 0, 0, 0, 1'b0};
    route[14] = '{KIND_SET, 17, 32'h8000_0000, 1'b1, 1'b0, 0, 0, 0, 1'b0};
    route[15] = '{KIND_TICK, 0, 32'h7FFF_FFFF, 1'b1, 1'b0, 0, 0, 0, 1'b0};
    route[16] = '{KIND_TICK, 36000, 32'h8000_0000, 1'b0, 1'b0, 0, 0, 0, 1'b0};
    route[17] = '{KIND_NONE, -1, 32'hFFFF_FFFF, 1'b1, 1'b0, 0, 0, 0, 1'b0};
    // re-arm keeps the gate open
    route[18] = '{KIND_ARM, 36000, 32'h0000_0000, 1'b0, 1'b1, 0, 0, 0, 1'b1};
    route[19] = '{KIND_TICK, 35999, 32'h0000_0001, 1'b1, 1'b0, 0, 0, 0, 1'b0};
    // widest yaw difference the field allows
    route[20] = '{KIND_ARM, -65536, 32'h0000_0000, 1'b1, 1'b1, 0, 0, 0, 1'b1};
    route[21] = '{KIND_TICK, 65535, 32'hFFFF_FFFF, 1'b1, 1'b0, 0, 0, 0, 1'b0};
    route[22] = '{KIND_SET, 65535, 32'h4000_0000, 1'b1, 1'b0, 0, 0, 0, 1'b0};
    route[23] = '{KIND_TICK, -65536, 32'hC000_0000, 1'b0, 1'b0, 0, 0, 0, 1'b0};
  endtask

  // Present one item, hold it until taken, then queue its pose
  task automatic offer_item(input route_row_t r);
    pose_t p;
    if ($urandom_range(0, 99) < feed_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 35)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= r.kind;
    in_ch.yaw_sample   <= r.yaw;
    in_ch.odo_distance <= r.distance;
    in_ch.enable       <= r.en;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    integrate_pose(r, p);
    if (r.typed) begin
      p.x       = r.ex;
      p.y       = r.ey;
      p.heading = r.eh;
      p.active  = r.ea;
    end
    pending_poses.push_back(p);
    items_sent++;
  endtask

  // Drop valid and wait for every queued pose, up to SETTLE_LIMIT
  task automatic settle_poses();
    int waited;
    in_ch.valid <= 1'b0;
    waited = 0;
    while (pending_poses.size() != 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  task automatic set_heading_negate(input logic v);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.heading_negate <= v;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    est_negate = v;
    cfg_ch.valid <= 1'b0;
  endtask

  // Drive HAUL_TICKS full-scale steps along one effective heading so that both axes clip
  task automatic run_haul(input int eff_hund);
    yaw_t  base;
    int    ang;
    int    yaw;
    dist_t d;
    base = yaw_t'(int'($urandom_range(0, 20000)) - 10000);
    offer_item(make_row(KIND_ARM, base, $urandom, $urandom_range(0, 1)));
    offer_item(make_row(KIND_SET, rand_yaw(), {16'h8000, 16'($urandom)}, 1'b1));
    for (int k = 0; k < HAUL_TICKS; k++) begin
      // odd steps run backward, so turn them by a half-turn
      ang = eff_hund + int'($urandom_range(0, 800)) - 400 + ((k % 2) ? 18000 : 0);
      if (est_negate) ang = -ang;
      yaw = int'(base) + ang;
      while (yaw > 36000) yaw = yaw - 36000;
      while (yaw < -36000) yaw = yaw + 36000;
      d = (k % 2) ? {16'h8000, 16'($urandom)} : {16'h7FFF, 16'($urandom)};
      offer_item(make_row(KIND_TICK, yaw_t'(yaw), d, $urandom_range(0, 1)));
    end
  endtask

  // Open the gate and move along with random heading and distance steps
  task automatic run_trip();
    dist_t odo;
    int    step;
    int    n;
    if ($urandom_range(0, 99) < 30)
      offer_item(make_row(KIND_ARM, rand_yaw(), $urandom, $urandom_range(0, 1)));
    odo = $urandom;
    offer_item(make_row(KIND_SET, rand_yaw(), odo, 1'b1));
    n = $urandom_range(4, 20);
    repeat (n) begin
      if ($urandom_range(0, 99) < 70) begin
        step = int'($urandom_range(0, 1 << 21)) - (1 << 20);
        odo = odo + step;
      end else begin
        odo = $urandom;
      end
      offer_item(make_row(KIND_TICK, rand_yaw(), odo, $urandom_range(0, 1)));
    end
  endtask

  // Result channel: random back-pressure
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Result check
  always @(posedge clk) begin
    pose_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_poses.size() == 0) begin
        log_mismatch($sformatf("unexpected pose x=%0d y=%0d heading=%0d active=%0b",
                               out_ch.pos_x, out_ch.pos_y, out_ch.heading, out_ch.is_active));
      end else begin
        want = pending_poses.pop_front();
        if (out_ch.pos_x !== want.x)
          log_mismatch($sformatf("pos_x expected %0d got %0d", want.x, out_ch.pos_x));
        if (out_ch.pos_y !== want.y)
          log_mismatch($sformatf("pos_y expected %0d got %0d", want.y, out_ch.pos_y));
        if (out_ch.heading !== want.heading)
          log_mismatch($sformatf("heading expected %0d got %0d", want.heading,
                                 out_ch.heading));
        if (out_ch.is_active !== want.active)
          log_mismatch($sformatf("is_active expected %0b got %0b", want.active,
                                 out_ch.is_active));
      end
    end
  end

  // Stimulus
  initial begin
    int phase_start;
    int pick;
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.kind            = '0;
    in_ch.yaw_sample      = '0;
    in_ch.odo_distance    = '0;
    in_ch.enable          = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.heading_negate = 1'b0;
    est_x                 = '0;
    est_y                 = '0;
    est_heading           = '0;
    est_offset            = '0;
    est_prev              = '0;
    est_active            = 1'b0;
    est_negate            = 1'b0;
    failures              = 0;
    items_sent            = 0;
    feed_idle_pct         = 0;
    sink_stall_pct        = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows
    set_heading_negate(1'b0);
    load_route();
    for (int i = 0; i < ROUTE_LEN; i++) offer_item(route[i]);
    settle_poses();

    // Random phases: none, feed idle, sink stall, both
    for (int p = 0; p < 4; p++) begin
      feed_idle_pct  = (p == 1) ? 71 : (p == 3) ? 33 : 0;
      sink_stall_pct = (p == 2) ? 71 : (p == 3) ? 33 : 0;
      set_heading_negate(p == 0 || p == 3);
      phase_start = items_sent;
      // clip both axes high, later both low
      if (p == 0) run_haul(4500);
      if (p == 2) run_haul(22500);
      while (items_sent - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          run_trip();
        end else if (pick < 85) begin
          repeat ($urandom_range(1, 5))
            offer_item(make_row($urandom_range(0, 3), rand_yaw(), $urandom,
                                $urandom_range(0, 1)));
        end else if (pick < 95) begin
          // close the gate, then stray ticks
          offer_item(make_row(KIND_SET, rand_yaw(), $urandom, 1'b0));
          repeat ($urandom_range(1, 3))
            offer_item(make_row(KIND_TICK, rand_yaw(), $urandom, $urandom_range(0, 1)));
        end else begin
          settle_poses();
        end
      end
      settle_poses();
    end

    if (failures == 0 && pending_poses.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/drpi_pkg.sv
design/drpi_ifs.sv
design/drpi_bam_div.sv
design/drpi_cordic.sv
design/dead_reckoning_pose_integrator.sv
tb/sv/tb_dead_reckoning_pose_integrator.sv
